@@ hw/rtl/t8cx_pkg.sv @@
// shared types, codes and helper functions for the 8-bit execute unit
`timescale 1ns / 1ps

package t8cx_pkg;

  typedef enum logic [4:0] {
    OP_MOV   = 5'd0,
    OP_LOAD  = 5'd1,
    OP_STORE = 5'd2,
    OP_ADD   = 5'd3,
    OP_SUB   = 5'd4,
    OP_ZERO  = 5'd5,
    OP_JMP   = 5'd6,
    OP_SHL   = 5'd7,
    OP_SHR   = 5'd8,
    OP_ROL   = 5'd9,
    OP_ROR   = 5'd10,
    OP_NEG   = 5'd11,
    OP_AND   = 5'd12,
    OP_OR    = 5'd13,
    OP_CMP   = 5'd14,
    OP_END   = 5'd15
  } op_t;

  typedef enum logic [1:0] {
    ST_RUN     = 2'd0,
    ST_END     = 2'd1,
    ST_ILLEGAL = 2'd2,
    ST_PAST    = 2'd3
  } status_t;

  // which register an instruction writes
  typedef enum logic [1:0] {
    DST_NONE = 2'd0,
    DST_A    = 2'd1,
    DST_B    = 2'd2,
    DST_R0   = 2'd3
  } dst_t;

  typedef struct packed {
    logic [8:0] pc;
    logic       zero;
    status_t    halt;
  } mach_state_t;

  typedef struct packed {
    logic [8:0] next_pc;
    logic [7:0] wv;
    logic       zero;
    status_t    status;
    logic       pc_we;
    logic       mem_we;
    dst_t       dst;
  } exec_res_t;

  // remainder by nine through five restoring steps
  function automatic logic [3:0] mod9(input logic [7:0] v);
    logic [8:0] r;
    r = {1'b0, v};
    for (int k = 4; k >= 0; k--) begin
      if (r >= 9'(9 << k)) begin
        r = r - 9'(9 << k);
      end
    end
    return r[3:0];
  endfunction

  function automatic logic [7:0] rotl8(input logic [7:0] v, input logic [2:0] k);
    logic [15:0] w;
    w = {v, v} << k;
    return w[15:8];
  endfunction

endpackage

@@ hw/rtl/t8cx_regfile.sv @@
// register file: two registered read ports, one write port, cleared by valid bits
`timescale 1ns / 1ps

module t8cx_regfile #(
  parameter int NUM_REGS = 8,
  parameter int AW = $clog2(NUM_REGS)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          re,
  input  logic [AW-1:0] ra_addr,
  input  logic [AW-1:0] rb_addr,
  input  logic          we,
  input  logic [AW-1:0] wa,
  input  logic [7:0]    wd,
  output logic [7:0]    ra_data,
  output logic [7:0]    rb_data
);

  logic [7:0]          mem [NUM_REGS];
  logic [NUM_REGS-1:0] vld;
  logic [7:0]          qa, qb, byp_data;
  logic                oka, okb, bypa, bypb;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[wa] <= 1'b1;
    end
  end

  // read data plus a bypass of a write landing on the same edge
  always_ff @(posedge clk) begin
    if (re) begin
      qa       <= mem[ra_addr];
      qb       <= mem[rb_addr];
      oka      <= vld[ra_addr];
      okb      <= vld[rb_addr];
      bypa     <= we && (wa == ra_addr);
      bypb     <= we && (wa == rb_addr);
      byp_data <= wd;
    end
  end

  assign ra_data = bypa ? byp_data : (oka ? qa : 8'd0);
  assign rb_data = bypb ? byp_data : (okb ? qb : 8'd0);

endmodule

@@ hw/rtl/t8cx_dmem.sv @@
// data memory: one registered read port, one write port, cleared by valid bits
`timescale 1ns / 1ps

module t8cx_dmem #(
  parameter int MEM_DEPTH = 256,
  parameter int AW = $clog2(MEM_DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          re,
  input  logic [AW-1:0] ra,
  input  logic          we,
  input  logic [AW-1:0] wa,
  input  logic [7:0]    wd,
  output logic [7:0]    rd
);

  logic [7:0]           mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] vld;
  logic [7:0]           q, byp_data;
  logic                 ok, byp;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      q        <= mem[ra];
      ok       <= vld[ra];
      byp      <= we && (wa == ra);
      byp_data <= wd;
    end
  end

  assign rd = byp ? byp_data : (ok ? q : 8'd0);

endmodule

@@ hw/rtl/t8cx_alu.sv @@
// instruction execute logic: result value, destination, flag, pc and status
`timescale 1ns / 1ps

module t8cx_alu (
  input  logic [4:0]           func,
  input  logic [7:0]           ra,
  input  logic [7:0]           rb,
  input  logic [7:0]           md,
  input  logic [8:0]           plen,
  input  t8cx_pkg::mach_state_t state,
  output t8cx_pkg::exec_res_t   res
);

  import t8cx_pkg::*;

  status_t    st;
  logic       exec;
  logic [8:0] nxt;
  logic [3:0] rot;

  always_comb begin
    rot        = mod9(ra);
    st         = state.halt;
    exec       = 1'b0;
    nxt        = state.pc;
    res.wv     = 8'd0;
    res.zero   = state.zero;
    res.dst    = DST_NONE;
    res.mem_we = 1'b0;
    if (st == ST_RUN && state.pc >= plen) begin
      st = ST_PAST;
    end
    if (st == ST_RUN) begin
      exec = 1'b1;
      nxt  = state.pc + 9'd1;
      unique case (func)
        OP_MOV:   begin res.wv = rb; res.dst = DST_A; end
        OP_LOAD:  begin res.wv = md; res.dst = DST_R0; end
        OP_STORE: begin res.wv = ra; res.mem_we = 1'b1; end
        OP_ADD:   begin res.wv = ra + rb; res.dst = DST_B; end
        OP_SUB:   begin res.wv = rb - ra; res.dst = DST_B; end
        OP_ZERO:  begin res.wv = 8'd0; res.dst = DST_A; end
        OP_JMP: begin
          if (state.zero) begin
            nxt = {1'b0, ra} + 9'd1;
          end
          res.zero = 1'b0;
        end
        OP_SHL: begin
          res.wv  = (ra >= 8'd8) ? 8'd0 : 8'(rb << ra[2:0]);
          res.dst = DST_B;
        end
        OP_SHR: begin
          res.wv  = (ra >= 8'd8) ? 8'd0 : (rb >> ra[2:0]);
          res.dst = DST_B;
        end
        OP_ROL:   begin res.wv = rotl8(rb, rot[2:0]); res.dst = DST_B; end
        OP_ROR: begin
          res.wv  = rotl8(rb, 3'(4'd8 - rot));
          res.dst = DST_B;
        end
        OP_NEG:   begin res.wv = 8'd255 - ra; res.dst = DST_A; end
        OP_AND:   begin res.wv = ra & rb; res.dst = DST_R0; end
        OP_OR:    begin res.wv = ra | rb; res.dst = DST_R0; end
        OP_CMP: begin
          if (ra == rb) begin
            res.zero = 1'b1;
          end
        end
        OP_END:   begin st = ST_END; exec = 1'b0; end
        default:  begin st = ST_ILLEGAL; exec = 1'b0; end
      endcase
      if (exec) begin
        if (nxt >= plen) begin
          st = ST_PAST;
        end
      end else begin
        nxt = state.pc;
      end
    end
    res.next_pc = nxt;
    res.status  = st;
    res.pc_we   = exec;
  end

endmodule

@@ hw/rtl/toy_8bit_cpu_execute_unit.sv @@
// top level of the 8-bit execute unit: read stage, execute stage, output register
`timescale 1ns / 1ps

//  channel   dir  handshake            payload
//  s_*       in   s_tvalid/s_tready    func, operand_a, operand_b
//  m_*       out  m_tvalid/m_tready    next_pc, written_value, zero_flag, status
//  cfg_*     in   cfg_we               program_length
//
//  accept to result: the register file and data memory read ports (registered),
//  then execute and write-back into the output register
//  one item per cycle while unstalled; a write in the execute stage is bypassed into
//  the read issued on the same edge, so dependent items follow back to back
//  rst is synchronous; the valid bits of both memories clear at once, no sweep
//  a held output stalls the execute stage, which in turn drops s_tready

module toy_8bit_cpu_execute_unit #(
  parameter int NUM_REGS  = 8,
  parameter int MEM_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // func[4:0], operand_a[12:5], operand_b[15:13]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // next_pc[8:0], written_value[16:9], zero_flag[17],
                                 // status[19:18], zero fill[23:20]
  input  logic        cfg_we,
  input  logic [8:0]  cfg_wdata  // program_length
);

  import t8cx_pkg::*;

  localparam int RW = $clog2(NUM_REGS);
  localparam int AW = $clog2(MEM_DEPTH);

  // three-bit index modulo the register count, restoring steps
  function automatic logic [RW-1:0] reg_idx(input logic [2:0] v);
    logic [4:0] r;
    r = {2'b00, v};
    for (int k = 2; k >= 0; k--) begin
      if (int'(r) >= (NUM_REGS << k)) begin
        r = r - 5'(NUM_REGS << k);
      end
    end
    return r[RW-1:0];
  endfunction

  // byte address modulo the memory depth
  function automatic logic [AW-1:0] mem_idx(input logic [7:0] v);
    logic [8:0] r;
    r = {1'b0, v};
    for (int k = 4; k >= 0; k--) begin
      if (int'(r) >= (MEM_DEPTH << k)) begin
        r = r - 9'(MEM_DEPTH << k);
      end
    end
    return r[AW-1:0];
  endfunction

  // input fields
  logic [4:0] in_func;
  logic [7:0] in_a;
  logic [2:0] in_b;
  logic       accept;

  // execute stage
  logic          s1_valid;
  logic [4:0]    s1_func;
  logic [RW-1:0] s1_ia, s1_ib;
  logic [AW-1:0] s1_addr;
  logic          fire;

  // architectural state outside the memories
  logic [8:0] pc;
  logic       zero;
  status_t    halt;
  logic [8:0] plen;

  // memory ports
  logic [RW-1:0] rd_a_idx, rd_b_idx, rf_wa;
  logic          rf_we, dm_we;
  logic [7:0]    ra_data, rb_data, md_data;

  mach_state_t state;
  exec_res_t   res;

  assign in_func = s_tdata[4:0];
  assign in_a    = s_tdata[12:5];
  assign in_b    = s_tdata[15:13];

  // execute stage frees up when the output register can take its result
  assign fire     = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || fire;
  assign accept   = s_tvalid && s_tready;

  // store reads r0 through port a; operand_a is then the address
  assign rd_a_idx = (in_func == OP_STORE) ? '0 : reg_idx(in_a[2:0]);
  assign rd_b_idx = reg_idx(in_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_func <= in_func;
      s1_ia   <= reg_idx(in_a[2:0]);
      s1_ib   <= rd_b_idx;
      s1_addr <= mem_idx(in_a);
    end
  end

  t8cx_regfile #(
    .NUM_REGS (NUM_REGS),
    .AW       (RW)
  ) u_regfile (
    .clk     (clk),
    .rst     (rst),
    .re      (accept),
    .ra_addr (rd_a_idx),
    .rb_addr (rd_b_idx),
    .we      (rf_we),
    .wa      (rf_wa),
    .wd      (res.wv),
    .ra_data (ra_data),
    .rb_data (rb_data)
  );

  t8cx_dmem #(
    .MEM_DEPTH (MEM_DEPTH),
    .AW        (AW)
  ) u_dmem (
    .clk (clk),
    .rst (rst),
    .re  (accept),
    .ra  (mem_idx(in_a)),
    .we  (dm_we),
    .wa  (s1_addr),
    .wd  (res.wv),
    .rd  (md_data)
  );

  assign state.pc   = pc;
  assign state.zero = zero;
  assign state.halt = halt;

  t8cx_alu u_alu (
    .func  (s1_func),
    .ra    (ra_data),
    .rb    (rb_data),
    .md    (md_data),
    .plen  (plen),
    .state (state),
    .res   (res)
  );

  // write-back of the executing item
  assign rf_we = fire && (res.dst != DST_NONE);
  assign dm_we = fire && res.mem_we;

  always_comb begin
    case (res.dst)
      DST_A:   rf_wa = s1_ia;
      DST_B:   rf_wa = s1_ib;
      default: rf_wa = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc   <= 9'd0;
      zero <= 1'b0;
      halt <= ST_RUN;
    end else if (fire) begin
      zero <= res.zero;
      halt <= res.status;
      if (res.pc_we) begin
        pc <= res.next_pc;
      end
    end
  end

  // program length; the user must write it only while idle, the block does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      plen <= 9'd0;
    end else if (cfg_we) begin
      plen <= cfg_wdata;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= {4'd0, res.status, res.zero, res.wv, res.next_pc};
    end
  end

  // a halted machine stays halted with the same status
  a_halt_holds: assert property (@(posedge clk) disable iff (rst)
    (halt != ST_RUN) |=> (halt == $past(halt)))
    else $error("halt status changed after halting");

  // no register or memory write once halted
  a_no_write_halted: assert property (@(posedge clk) disable iff (rst)
    (rf_we || dm_we) |-> (halt == ST_RUN))
    else $error("write while halted");

  // an executing item is kept while the output register is blocked
  a_s1_kept: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && m_tvalid && !m_tready) |=> s1_valid)
    else $error("execute stage item lost under stall");

endmodule
